FILE: design/band_chained_table_with_free_list_defines.svh
// Assertion macros for the band chained descriptor table.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BAND_CHAINED_TABLE_WITH_FREE_LIST_DEFINES_SVH
`define BAND_CHAINED_TABLE_WITH_FREE_LIST_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BCTFL_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BCTFL_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: design/bctfl_pkg.sv
// Package for the band chained descriptor table: beat types, codes, defaults.
// No dependencies.
package bctfl_pkg;

  localparam int unsigned DEF_NUM_BANDS = 256;
  localparam int unsigned DEF_POOL_SIZE = 256;
  localparam int unsigned DEF_GRAIN     = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BAND_W   = 8;
  localparam int unsigned DESC_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BAND_W-1:0] band;
    logic [DESC_W-1:0] desc_in;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DESC_W-1:0]   desc_out;
    logic                last;
    logic [COUNT_W-1:0]  removed_count;
  } out_t;

endpackage

FILE: design/bctfl_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module bctfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/band_chained_table_with_free_list.sv
// Band chained descriptor table: per-band linked lists in a shared node pool, stack free list.
// Steps: lookup reads the head, then the node; insert pops a free node, then walks the links to
// the tail; delete unlinks one node per step, up to GRAIN removals; one link RAM read per step sets the pace.
// One item at a time; ready again in the cycle its last beat reaches the output.
// Reset (rst_ni low, async): all heads null via valid bits, free stack at node 0, no clear pass.
// Depends on bctfl_pkg, bctfl_ram and band_chained_table_with_free_list_defines.svh.
`include "band_chained_table_with_free_list_defines.svh"

module band_chained_table_with_free_list #(
  parameter int unsigned NUM_BANDS = bctfl_pkg::DEF_NUM_BANDS,
  parameter int unsigned POOL_SIZE = bctfl_pkg::DEF_POOL_SIZE,
  parameter int unsigned GRAIN     = bctfl_pkg::DEF_GRAIN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bctfl_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bctfl_pkg::out_t  out_data_o
);

  import bctfl_pkg::*;

  // Only 256 band ids can be addressed by the band field.
  localparam int unsigned HEAD_DEPTH = (NUM_BANDS < 256) ? NUM_BANDS : 256;
  localparam int unsigned HIDX_W     = $clog2(HEAD_DEPTH);
  localparam int unsigned PTR_W      = $clog2(POOL_SIZE + 1);  // node index plus null
  localparam int unsigned NIDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W      = $clog2(GRAIN + 1);
  localparam int unsigned NODE_W     = BAND_W + DESC_W;

  localparam logic [PTR_W-1:0] NIL     = PTR_W'(POOL_SIZE);
  localparam logic [CNT_W:0]   GRAIN_L = (CNT_W + 1)'(GRAIN);
  localparam logic [16:0]      NB_L    = 17'(NUM_BANDS);

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HEAD = 8'b0000_0010,  // head pointer back from RAM, dispatch on command
    S_LOOK = 8'b0000_0100,  // lookup: node data ready
    S_POP  = 8'b0000_1000,  // insert: pop free stack, write new node
    S_WALK = 8'b0001_0000,  // insert: follow links to the tail
    S_DEL  = 8'b0010_0000,  // delete: unlink one node per step
    S_FIN  = 8'b0100_0000,  // delete: send the held beat as last
    S_RESP = 8'b1000_0000   // single status-only beat
  } state_e;

  state_e state_q, state_d;

  // Captured item
  logic [CMD_W-1:0]  cmd_q;
  logic [BAND_W-1:0] band_q;
  logic [DESC_W-1:0] desc_q;
  logic              band_ok_q;

  // Walk and free list state
  logic [PTR_W-1:0] cur_q, cur_d;
  logic [PTR_W-1:0] new_node_q, new_node_d;
  logic [PTR_W-1:0] free_top_q, free_top_d;
  // Nodes at or above fresh_q were never handed out; their link is implicitly i+1.
  logic [PTR_W-1:0] fresh_q, fresh_d;

  // Delete holds back one result until it knows whether that result is the last
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_v_q, pend_v_d;
  logic [DESC_W-1:0]   pend_desc_q, pend_desc_d;
  logic [STATUS_W-1:0] resp_q, resp_d;

  // Head valid bits stand in for the null reset of the head RAM
  logic [HEAD_DEPTH-1:0] head_vld_q;
  logic                  head_vld_rd_q;

  // RAM ports
  logic              head_we;
  logic [HIDX_W-1:0] head_waddr, head_raddr;
  logic [PTR_W-1:0]  head_wdata, head_rdata;
  logic              node_we;
  logic [NIDX_W-1:0] node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;
  logic              link_we;
  logic [NIDX_W-1:0] link_waddr, link_raddr;
  logic [PTR_W-1:0]  link_wdata, link_rdata;

  // Output register
  logic out_valid_q;
  out_t out_q;
  logic emit_v;
  out_t emit_data;
  logic out_free;

  logic              accept;
  logic [PTR_W-1:0]  head_ptr;
  logic [BAND_W-1:0] node_band;
  logic [DESC_W-1:0] node_desc;
  logic [31:0]       cnt_w;
  logic [4:0]        cnt_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign head_ptr  = head_vld_rd_q ? head_rdata : NIL;
  assign node_band = node_rdata[NODE_W-1:DESC_W];
  assign node_desc = node_rdata[DESC_W-1:0];
  assign cnt_w     = 32'(cnt_q);
  assign cnt_out   = cnt_w[4:0];

  bctfl_ram #(.WIDTH(PTR_W), .DEPTH(HEAD_DEPTH)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  bctfl_ram #(.WIDTH(NODE_W), .DEPTH(POOL_SIZE)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  bctfl_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SIZE)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Sequencer: one RAM access per port per cycle
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    new_node_d  = new_node_q;
    free_top_d  = free_top_q;
    fresh_d     = fresh_q;
    cnt_d       = cnt_q;
    pend_v_d    = pend_v_q;
    pend_desc_d = pend_desc_q;
    resp_d      = resp_q;

    head_we    = 1'b0;
    head_waddr = band_q[HIDX_W-1:0];
    head_wdata = free_top_q;
    head_raddr = in_data_i.band[HIDX_W-1:0];
    node_we    = 1'b0;
    node_waddr = free_top_q[NIDX_W-1:0];
    node_wdata = {band_q, desc_q};
    node_raddr = cur_q[NIDX_W-1:0];  // held address keeps read data stable on a stall
    link_we    = 1'b0;
    link_waddr = cur_q[NIDX_W-1:0];
    link_wdata = NIL;
    link_raddr = cur_q[NIDX_W-1:0];

    emit_v    = 1'b0;
    emit_data = '0;

    case (state_q)
      S_IDLE: begin
        if (accept && (in_data_i.cmd != CMD_NONE)) begin
          state_d = S_HEAD;
        end
      end

      S_HEAD: begin
        cur_d    = head_ptr;
        cnt_d    = '0;
        pend_v_d = 1'b0;
        case (cmd_q)
          CMD_LOOKUP: begin
            if (!band_ok_q || (head_ptr == NIL)) begin
              resp_d  = STAT_NOT_FOUND;
              state_d = S_RESP;
            end else begin
              node_raddr = head_ptr[NIDX_W-1:0];
              state_d    = S_LOOK;
            end
          end
          CMD_INSERT: begin
            if (!band_ok_q) begin
              resp_d  = STAT_NOT_FOUND;
              state_d = S_RESP;
            end else if (free_top_q == NIL) begin
              resp_d  = STAT_FULL;
              state_d = S_RESP;
            end else begin
              link_raddr = free_top_q[NIDX_W-1:0];
              state_d    = S_POP;
            end
          end
          CMD_DELETE: begin
            if (!band_ok_q || (head_ptr == NIL)) begin
              resp_d  = STAT_NOT_FOUND;
              state_d = S_RESP;
            end else begin
              node_raddr = head_ptr[NIDX_W-1:0];
              link_raddr = head_ptr[NIDX_W-1:0];
              state_d    = S_DEL;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_LOOK: begin
        if (out_free) begin
          emit_v             = 1'b1;
          emit_data.status   = STAT_OK;
          emit_data.desc_out = node_desc;
          emit_data.last     = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_POP: begin
        // New node becomes the tail: write its data and a null link
        node_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = free_top_q[NIDX_W-1:0];
        link_wdata = NIL;
        new_node_d = free_top_q;
        if (free_top_q >= fresh_q) begin
          free_top_d = free_top_q + PTR_W'(1);
          fresh_d    = fresh_q + PTR_W'(1);
        end else begin
          free_top_d = link_rdata;
        end
        if (cur_q == NIL) begin
          head_we = 1'b1;
          resp_d  = STAT_OK;
          state_d = S_RESP;
        end else begin
          state_d = S_WALK;  // link read at cur_q issued by default
        end
      end

      S_WALK: begin
        if (link_rdata == NIL) begin
          link_we    = 1'b1;
          link_wdata = new_node_q;
          resp_d     = STAT_OK;
          state_d    = S_RESP;
        end else begin
          cur_d      = link_rdata;
          link_raddr = link_rdata[NIDX_W-1:0];
        end
      end

      S_DEL: begin
        if (out_free) begin
          if (node_band == band_q) begin
            // Unlink the front node and push it on the free stack
            if (pend_v_q) begin
              emit_v                  = 1'b1;
              emit_data.status        = STAT_OK;
              emit_data.desc_out      = pend_desc_q;
              emit_data.removed_count = cnt_out;
            end
            head_we     = 1'b1;
            head_wdata  = link_rdata;
            link_we     = 1'b1;
            link_wdata  = free_top_q;
            free_top_d  = cur_q;
            pend_v_d    = 1'b1;
            pend_desc_d = node_desc;
            cnt_d       = cnt_q + CNT_W'(1);
            if ((({1'b0, cnt_q} + (CNT_W + 1)'(1)) == GRAIN_L) || (link_rdata == NIL)) begin
              state_d = S_FIN;
            end else begin
              cur_d      = link_rdata;
              node_raddr = link_rdata[NIDX_W-1:0];
              link_raddr = link_rdata[NIDX_W-1:0];
            end
          end else begin
            // Foreign tag stops the delete early
            emit_v         = 1'b1;
            emit_data.last = 1'b1;
            if (pend_v_q) begin
              emit_data.status        = STAT_OK;
              emit_data.desc_out      = pend_desc_q;
              emit_data.removed_count = cnt_out;
            end else begin
              emit_data.status = STAT_NOT_FOUND;
            end
            state_d = S_IDLE;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit_v                  = 1'b1;
          emit_data.status        = STAT_OK;
          emit_data.desc_out      = pend_desc_q;
          emit_data.last          = 1'b1;
          emit_data.removed_count = cnt_out;
          state_d                 = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit_v           = 1'b1;
          emit_data.status = resp_q;
          emit_data.last   = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      free_top_q    <= '0;
      fresh_q       <= '0;
      pend_v_q      <= 1'b0;
      head_vld_q    <= '0;
      head_vld_rd_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      free_top_q    <= free_top_d;
      fresh_q       <= fresh_d;
      pend_v_q      <= pend_v_d;
      head_vld_rd_q <= head_vld_q[head_raddr];
      if (head_we) begin
        head_vld_q[head_waddr] <= 1'b1;
      end
      if (emit_v) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_data_i.cmd;
      band_q    <= in_data_i.band;
      desc_q    <= in_data_i.desc_in;
      band_ok_q <= ({9'd0, in_data_i.band} < NB_L);
    end
    cur_q       <= cur_d;
    new_node_q  <= new_node_d;
    cnt_q       <= cnt_d;
    pend_desc_q <= pend_desc_d;
    resp_q      <= resp_d;
    if (emit_v) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A free top at or above the fresh mark must be exactly the next unused node
  `BCTFL_ASSERT_IMP(a_fresh_top, (free_top_q != NIL) && (free_top_q >= fresh_q), free_top_q == fresh_q, "free top skipped an unused node")
  // An empty free stack means every node has been handed out once
  `BCTFL_ASSERT_IMP(a_pool_used, free_top_q == NIL, fresh_q == NIL, "free stack empty with unused nodes left")
  // A delete step never starts with the grain already used up
  `BCTFL_ASSERT_IMP(a_grain, state_q == S_DEL, {1'b0, cnt_q} < GRAIN_L, "delete ran past grain")
  // Closing a delete needs a held result
  `BCTFL_ASSERT_IMP(a_fin_pend, state_q == S_FIN, pend_v_q, "final delete beat without held result")
  // A valid command leads straight to the head dispatch
  `BCTFL_ASSERT_NXT(a_dispatch, accept && (in_data_i.cmd != CMD_NONE), state_q == S_HEAD, "accepted command not dispatched")

endmodule
